### rtl/pgmsp_pkg.sv
package pgmsp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC0 = 3'd0,
        PH_MAGIC1 = 3'd1,
        PH_SEP    = 3'd2,
        PH_WIDTH  = 3'd3,
        PH_HEIGHT = 3'd4,
        PH_MAXVAL = 3'd5,
        PH_PIXELS = 3'd6,
        PH_IDLE   = 3'd7
    } t_phase;

    localparam logic [1:0] KIND_WIDTH  = 2'd0;
    localparam logic [1:0] KIND_HEIGHT = 2'd1;
    localparam logic [1:0] KIND_MAXVAL = 2'd2;
    localparam logic [1:0] KIND_PIXEL  = 2'd3;

    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
    localparam logic [20:0] CHAR_ZERO    = 21'd48;
    localparam logic [15:0] NARROW_MAX   = 16'h00FF;

    // one input item as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    // status of the input register as seen by the parser core
    typedef struct packed {
        logic valid;
    } t_stage_ctl;

endpackage

### rtl/pgmsp_in_stage.sv
module pgmsp_in_stage
    import pgmsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       i_take,
    output logic       o_valid,
    output t_in_item   o_item
);

    logic     r_valid;
    t_in_item r_item;

    // accept when empty or when the held item leaves this cycle
    assign s_tready = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_tready) begin
            r_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item.data_byte <= s_tdata;
            r_item.restart   <= s_tuser;
        end
    end

endmodule

### rtl/pgmsp_core.sv
module pgmsp_core
    import pgmsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stage_ctl  i_ctl_in,
    input  t_in_item    i_item,
    output logic        o_take,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    function automatic logic [15:0] accumulate(input logic [15:0] acc, input logic [7:0] b);
        logic [20:0] sum;
        logic [20:0] v;
        begin
            sum = {1'b0, acc, 4'b0} - {4'b0, acc, 1'b0} - {3'b0, acc, 2'b0}
                + {13'd0, b};
            v = sum - CHAR_ZERO;
            if (sum < CHAR_ZERO) begin
                accumulate = 16'd0;
            end else if (v > 21'd65535) begin
                accumulate = 16'hFFFF;
            end else begin
                accumulate = v[15:0];
            end
        end
    endfunction

    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] r_pix_left, n_pix_left;
    logic [7:0]  r_high, n_high;
    logic        r_toggle, n_toggle;
    logic        r_wide, n_wide;

    logic        r_out_valid;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_value, n_value;
    logic        r_out_wide, n_out_wide;
    logic        r_last, n_last;

    t_phase      c_phase;
    logic [15:0] c_acc, c_width;
    logic [31:0] c_pix_left, dec_pix;
    logic [15:0] c_sample;
    logic [7:0]  c_high;
    logic        c_toggle, c_wide;
    logic        emit;

    // process the held item once the result register is free
    assign o_take   = i_ctl_in.valid && (!r_out_valid || m_tready);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_value;
    assign m_tuser  = {r_out_wide, r_kind};
    assign m_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC0;
            r_acc      <= 16'd0;
            r_width    <= 16'd0;
            r_height   <= 16'd0;
            r_pix_left <= 32'd0;
            r_high     <= 8'd0;
            r_toggle   <= 1'b0;
            r_wide     <= 1'b0;
        end else if (o_take) begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_width    <= n_width;
            r_height   <= n_height;
            r_pix_left <= n_pix_left;
            r_high     <= n_high;
            r_toggle   <= n_toggle;
            r_wide     <= n_wide;
        end
    end

    always_comb begin
        // restart: parse this byte against the reset state
        c_phase    = i_item.restart ? PH_MAGIC0 : r_phase;
        c_acc      = i_item.restart ? 16'd0 : r_acc;
        c_width    = i_item.restart ? 16'd0 : r_width;
        c_pix_left = i_item.restart ? 32'd0 : r_pix_left;
        c_high     = i_item.restart ? 8'd0 : r_high;
        c_toggle   = i_item.restart ? 1'b0 : r_toggle;
        c_wide     = i_item.restart ? 1'b0 : r_wide;
        dec_pix    = c_pix_left - 32'd1;
        c_sample   = c_wide ? {c_high, i_item.data_byte} : {8'd0, i_item.data_byte};

        n_phase    = c_phase;
        n_acc      = c_acc;
        n_width    = c_width;
        n_height   = i_item.restart ? 16'd0 : r_height;
        n_pix_left = c_pix_left;
        n_high     = c_high;
        n_toggle   = c_toggle;
        n_wide     = c_wide;
        emit       = 1'b0;
        n_kind     = KIND_PIXEL;
        n_value    = c_sample;
        n_out_wide = 1'b0;
        n_last     = 1'b0;

        unique case (c_phase)
            PH_MAGIC0: n_phase = PH_MAGIC1;
            PH_MAGIC1: n_phase = PH_SEP;
            PH_SEP: begin
                n_phase = PH_WIDTH;
                n_acc   = 16'd0;
            end
            PH_WIDTH: begin
                if (i_item.data_byte == CHAR_SPACE) begin
                    n_width = c_acc;
                    n_acc   = 16'd0;
                    n_phase = PH_HEIGHT;
                    emit    = 1'b1;
                    n_kind  = KIND_WIDTH;
                    n_value = c_acc;
                end else begin
                    n_acc = accumulate(c_acc, i_item.data_byte);
                end
            end
            PH_HEIGHT: begin
                if (i_item.data_byte == CHAR_NEWLINE) begin
                    n_height   = c_acc;
                    n_acc      = 16'd0;
                    n_pix_left = {16'd0, c_width} * {16'd0, c_acc};
                    n_phase    = PH_MAXVAL;
                    emit       = 1'b1;
                    n_kind     = KIND_HEIGHT;
                    n_value    = c_acc;
                end else begin
                    n_acc = accumulate(c_acc, i_item.data_byte);
                end
            end
            PH_MAXVAL: begin
                if (i_item.data_byte == CHAR_NEWLINE) begin
                    n_acc      = 16'd0;
                    n_wide     = (c_acc > NARROW_MAX);
                    n_toggle   = 1'b0;
                    n_phase    = (c_pix_left == 32'd0) ? PH_IDLE : PH_PIXELS;
                    emit       = 1'b1;
                    n_kind     = KIND_MAXVAL;
                    n_value    = c_acc;
                    n_out_wide = (c_acc > NARROW_MAX);
                end else begin
                    n_acc = accumulate(c_acc, i_item.data_byte);
                end
            end
            PH_PIXELS: begin
                if (c_wide && !c_toggle) begin
                    n_high   = i_item.data_byte;
                    n_toggle = 1'b1;
                end else begin
                    n_toggle   = 1'b0;
                    n_pix_left = dec_pix;
                    emit       = 1'b1;
                    n_out_wide = c_wide;
                    n_last     = (dec_pix == 32'd0);
                    if (dec_pix == 32'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_IDLE: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_kind     <= n_kind;
            r_value    <= n_value;
            r_out_wide <= n_out_wide;
            r_last     <= n_last;
        end
    end

endmodule

### rtl/pgm_stream_parser.sv
// Byte-serial parser for binary grey-map (P5) files. Feed the file one byte per
// item on the slave side; set s_tuser on the first byte of each file to restart.
// The first two bytes and the separator are skipped, then width (ended by a
// space), height (ended by a newline) and maximum value (ended by a newline) are
// reported as header items, followed by exactly width*height pixel samples with
// the final one marked by m_tlast. A maximum value above 255 selects 16-bit
// samples, most significant byte first. Any byte other than the terminator folds
// into the header number as 10*n + (byte - 48), clamped to 0..65535. Bytes past
// the last sample are dropped until the next restart. The block takes one byte
// every cycle while the master side is not stalled; each byte is held in the
// input register, and its result in the parser's result register.
module pgm_stream_parser
    import pgmsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] restart
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] value
    output logic [2:0]  m_tuser,   // [1:0] kind, [2] wide_samples
    output logic        m_tlast    // final pixel sample
);

    t_in_item   w_item;
    t_stage_ctl w_ctl;
    logic       w_valid;
    logic       w_take;

    // hold the accepted byte until the parser core can take it
    pgmsp_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .i_take   (w_take),
        .o_valid  (w_valid),
        .o_item   (w_item)
    );

    assign w_ctl.valid = w_valid;

    // advance the header and pixel state, and register each result item
    pgmsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl_in (w_ctl),
        .i_item   (w_item),
        .o_take   (w_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/pgmsp_checker.sv
module pgmsp_checker
    import pgmsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser[1:0] == KIND_PIXEL)
        else $error("last marked on a header item");

    a_header_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser[1:0] == KIND_WIDTH || m_tuser[1:0] == KIND_HEIGHT)
        |-> !m_tuser[2])
        else $error("wide flag set on width or height item");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result item changed");

endmodule

bind pgm_stream_parser pgmsp_checker u_checker (.*);

### sim/tb_pgm_stream_parser.sv
`timescale 1ns / 100ps

module tb_pgm_stream_parser
    import pgmsp_pkg::*;
;

    localparam int          LIMIT_CYCLES = 400000;
    localparam int          RANDOM_BYTES = 1200;
    localparam int          DRAIN_EVERY  = 400;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          DEC_BASE     = 10;
    localparam logic [7:0]  MAGIC_P      = 8'h50;
    localparam logic [7:0]  MAGIC_5      = 8'h35;
    localparam logic [7:0]  DIGIT_ZERO   = CHAR_ZERO[7:0];

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        wide;
        logic        last;
    } t_pgm_result;

    // Parser mirror: tracks the header and pixel count, queues the items the block owes.
    class pgm_scoreboard;
        t_phase        phase;
        logic [15:0]   acc;
        logic [15:0]   img_w;
        logic [15:0]   img_h;
        logic [31:0]   pix_left;
        logic [7:0]    hi_byte;
        logic          toggle;
        logic          wide;
        t_pgm_result   expected_q[$];
        int            errors;

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            phase    = PH_MAGIC0;
            acc      = '0;
            img_w    = '0;
            img_h    = '0;
            pix_left = '0;
            hi_byte  = '0;
            toggle   = 1'b0;
            wide     = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Any byte other than the terminator folds in as a decimal digit, clamped to 16 bits.
        function logic [15:0] fold_digit(logic [15:0] a, logic [7:0] b);
            int v;
            v = int'(a) * DEC_BASE + int'(b) - int'(CHAR_ZERO);
            if (v < 0) return 16'd0;
            if (v > 65535) return 16'hFFFF;
            return v[15:0];
        endfunction

        function void owe(logic [1:0] kind, logic [15:0] value, logic w, logic l);
            t_pgm_result r;
            r.kind  = kind;
            r.value = value;
            r.wide  = w;
            r.last  = l;
            expected_q.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b, logic rs);
            logic [15:0] v;
            if (rs) clear_state();
            case (phase)
                PH_MAGIC0: phase = PH_MAGIC1;
                PH_MAGIC1: phase = PH_SEP;
                PH_SEP: begin
                    phase = PH_WIDTH;
                    acc   = '0;
                end
                PH_WIDTH: begin
                    if (b == CHAR_SPACE) begin
                        img_w = acc;
                        acc   = '0;
                        phase = PH_HEIGHT;
                        owe(KIND_WIDTH, img_w, 1'b0, 1'b0);
                    end else begin
                        acc = fold_digit(acc, b);
                    end
                end
                PH_HEIGHT: begin
                    if (b == CHAR_NEWLINE) begin
                        img_h    = acc;
                        acc      = '0;
                        pix_left = {16'd0, img_w} * {16'd0, img_h};
                        phase    = PH_MAXVAL;
                        owe(KIND_HEIGHT, img_h, 1'b0, 1'b0);
                    end else begin
                        acc = fold_digit(acc, b);
                    end
                end
                PH_MAXVAL: begin
                    if (b == CHAR_NEWLINE) begin
                        v      = acc;
                        acc    = '0;
                        wide   = (v > NARROW_MAX);
                        toggle = 1'b0;
                        phase  = (pix_left == 0) ? PH_IDLE : PH_PIXELS;
                        owe(KIND_MAXVAL, v, wide, 1'b0);
                    end else begin
                        acc = fold_digit(acc, b);
                    end
                end
                PH_PIXELS: begin
                    // hold the high byte of a wide sample until its partner arrives
                    if (wide && !toggle) begin
                        hi_byte = b;
                        toggle  = 1'b1;
                        return;
                    end
                    if (wide) begin
                        toggle = 1'b0;
                        v      = {hi_byte, b};
                    end else begin
                        v = {8'd0, b};
                    end
                    pix_left = pix_left - 1;
                    if (pix_left == 0) begin
                        phase = PH_IDLE;
                        owe(KIND_PIXEL, v, wide, 1'b1);
                    end else begin
                        owe(KIND_PIXEL, v, wide, 1'b0);
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] %s", $time, what);
        endtask

        task check_result(logic [1:0] kind, logic [15:0] value, logic w, logic l);
            t_pgm_result want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind %0d value %h", kind, value));
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
            if (value !== want.value)
                report_mismatch($sformatf("value %h, wanted %h (kind %0d)",
                                          value, want.value, want.kind));
            if (w !== want.wide)
                report_mismatch($sformatf("wide flag %b, wanted %b", w, want.wide));
            if (l !== want.last)
                report_mismatch($sformatf("last flag %b, wanted %b", l, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] restart
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] value
    logic [2:0]  m_tuser;   // [1:0] kind, [2] wide_samples
    logic        m_tlast;

    pgm_scoreboard sb;
    int            burst_left;
    int            bytes_sent;
    int            cycles;
    int            rx_mode;
    int            rx_count;

    pgm_stream_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("pgm_stream_parser: mismatch");
            $finish;
        end
    end

    // Receiver: switch among always-ready, coin-flip, mostly-stalled and a fixed duty pattern.
    always @(negedge i_clk) begin
        rx_count++;
        if (rx_count % 97 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ((rx_count % 11) < 7);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_result(m_tuser[1:0], m_tdata, m_tuser[2], m_tlast);
    end

    // Offer one byte; may idle first when the current burst is used up. Called at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 5))
                0, 1, 2: gap = 0;
                3, 4:    gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 20);
            endcase
            burst_left = $urandom_range(1, 32);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rs;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(b, rs);
        bytes_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_number(input int n, input int zeros);
        string s;
        int    i;
        s = $sformatf("%0d", n);
        repeat (zeros) send_byte(DIGIT_ZERO, 1'b0);
        for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // Header, then nbytes random sample bytes and trail extra bytes.
    task automatic send_image(input logic rs, input int w, input int h, input int mx,
                              input int nbytes, input int trail, input int zeros);
        send_byte(MAGIC_P, rs);
        send_byte(MAGIC_5, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_number(w, zeros);
        send_byte(CHAR_SPACE, 1'b0);
        send_number(h, 0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_number(mx, zeros);
        send_byte(CHAR_NEWLINE, 1'b0);
        repeat (nbytes + trail) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Stop offering and hold until every owed item has come out.
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        int start_count;
        int next_drain;
        int w, h, mx, full, zeros;
        logic [7:0] junk;

        sb         = new();
        burst_left = 0;
        bytes_sent = 0;
        cycles     = 0;
        rx_mode    = 0;
        rx_count   = 0;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        m_tready   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // narrow image straight out of reset without the restart flag; trailing bytes dropped
        send_image(1'b0, 3, 2, 255, 0, 0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        // smallest maximum value that selects wide samples
        send_image(1'b1, 2, 1, 256, 0, 0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        // full-range maximum; restart lands between the two halves of a sample
        send_image(1'b1, 2, 2, 65535, 0, 0, 0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h12, 1'b0);
        send_image(1'b1, 1, 1, 65535, 2, 0, 0);
        // empty images: widest width with zero height, then clamped header numbers
        send_image(1'b1, 65535, 0, 0, 0, 2, 1);
        send_image(1'b1, 99999, 0, 70000, 0, 2, 1);
        // junk inside the header: newline in width, bytes below the digit range, a letter
        send_byte(MAGIC_P, 1'b1);
        send_byte(MAGIC_5, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte(DIGIT_ZERO + 8'd1, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte(DIGIT_ZERO + 8'd2, 1'b0);
        send_byte(CHAR_SPACE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CHAR_SPACE, 1'b0);
        send_byte(DIGIT_ZERO + 8'd3, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);
        // restart in the middle of a header, then a complete wide image
        send_byte(MAGIC_P, 1'b1);
        send_byte(MAGIC_5, 1'b0);
        send_byte(CHAR_NEWLINE, 1'b0);
        send_byte(DIGIT_ZERO + 8'd4, 1'b0);
        send_image(1'b1, 1, 3, 300, 6, 0, 0);
        wait_drained();

        start_count = bytes_sent;
        next_drain  = bytes_sent + DRAIN_EVERY;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0:       begin w = $urandom_range(0, 65535); h = 0; end
                1:       begin w = 0; h = $urandom_range(0, 65535); end
                2:       begin w = $urandom_range(1, 40); h = $urandom_range(1, 3); end
                default: begin w = $urandom_range(0, 6); h = $urandom_range(0, 6); end
            endcase
            case ($urandom_range(0, 5))
                0:       mx = 255;
                1:       mx = 256;
                2:       mx = 65535;
                3:       mx = $urandom_range(256, 65535);
                default: mx = $urandom_range(0, 255);
            endcase
            full  = w * h * ((mx > 255) ? 2 : 1);
            zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
            case ($urandom_range(0, 19))
                15, 16: begin
                    // cut short; the next file's restart abandons it
                    send_image(1'b1, w, h, mx, (full > 0) ? $urandom_range(0, full - 1) : 0,
                               0, zeros);
                end
                17, 18: begin
                    send_byte(8'($urandom_range(0, 255)), 1'b1);
                    repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b0);
                    repeat ($urandom_range(3, 16)) begin
                        case ($urandom_range(0, 3))
                            0:       junk = DIGIT_ZERO + 8'($urandom_range(0, 9));
                            1:       junk = CHAR_SPACE;
                            2:       junk = CHAR_NEWLINE;
                            default: junk = 8'($urandom_range(0, 255));
                        endcase
                        send_byte(junk, 1'b0);
                    end
                    repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                19: begin
                    repeat ($urandom_range(1, 20))
                        send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
                end
                default: begin
                    send_image(1'b1, w, h, mx, full,
                               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, zeros);
                end
            endcase
            if (bytes_sent >= next_drain) begin
                wait_drained();
                next_drain = bytes_sent + DRAIN_EVERY;
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d items never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("pgm_stream_parser: match");
        end else begin
            $display("pgm_stream_parser: mismatch");
        end
        $finish;
    end

endmodule
